// File: rtl/core/substring_locator_top_macros.svh
// Assertion helpers shared by the substring locator RTL.
// Every check is sampled on the rising edge of clk and is idle during reset.
`ifndef SUBSTRING_LOCATOR_TOP_MACROS_SVH
`define SUBSTRING_LOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define SL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/subloc_pkg.sv
`default_nettype none

package subloc_pkg;

  // Register file layout
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W = 5;
  localparam int OFFSET_W = 16;
  localparam int POS_OUT_W = 16;
  localparam int PATTERN_BYTES = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_REVERSE = 3'd4;

  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 5'd1;

  // Input word
  typedef struct packed {
    logic [7:0] source_byte;
    logic       last_byte;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic                 found;
    logic [POS_OUT_W-1:0] match_position;
    logic                 overlong;
  } out_word_t;

  // Per-byte status from the cell row to the position tracker
  typedef struct packed {
    logic take;   // a byte is accepted this cycle
    logic last;   // it closes the string
    logic hit;    // a full pattern occurrence ends on it
  } step_t;

endpackage

`default_nettype wire

// File: rtl/core/subloc_cell.sv
`default_nettype none

// One partial-match cell: bit i says pattern bytes 0..i end on the current byte.
module subloc_cell (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       shift,      // byte accepted
  input  wire logic       clear,      // byte accepted and it ends the string
  input  wire logic       active,     // cell lies inside the pattern length
  input  wire logic [7:0] pat_byte,
  input  wire logic [7:0] src_byte,
  input  wire logic       match_in,   // previous cell's bit, or 1 for the head cell
  output logic            match_r,
  output logic            match_nxt
);

  // Extend the neighbor's partial match by one byte
  assign match_nxt = match_in & active & (pat_byte == src_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (clear) begin
      match_r <= 1'b0;
    end else if (shift) begin
      match_r <= match_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/subloc_tracker.sv
`default_nettype none

`include "substring_locator_top_macros.svh"

// Byte position, kept occurrence and the registered result word.
module subloc_tracker #(
  parameter int POSITION_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire subloc_pkg::step_t              step,
  input  wire logic [subloc_pkg::LEN_W-1:0]   eff_len,
  input  wire logic [subloc_pkg::OFFSET_W-1:0] start_offset,
  input  wire logic                           search_reverse,
  input  wire logic                           out_stall,
  output logic                                out_valid,
  output subloc_pkg::out_word_t               out_data
);

  localparam int CW = (POSITION_BITS > subloc_pkg::POS_OUT_W) ? POSITION_BITS
                                                               : subloc_pkg::POS_OUT_W;

  logic [POSITION_BITS-1:0] byte_count_r;
  logic [POSITION_BITS-1:0] byte_count_nxt;
  logic                     have_hit_r;
  logic                     have_hit_nxt;
  logic [CW-1:0]            hit_pos_r;
  logic [CW-1:0]            hit_pos_nxt;
  logic                     sat_r;
  logic                     sat_nxt;
  logic                     out_valid_r;
  subloc_pkg::out_word_t    out_data_r;
  subloc_pkg::out_word_t    out_data_nxt;

  logic          saturated;
  logic [CW-1:0] start_w;
  logic [CW-1:0] count_ext;
  logic          qualify;
  logic          record;

  // Count saturates at all ones; a byte arriving then is out of range
  assign saturated      = &byte_count_r;
  assign byte_count_nxt = saturated ? byte_count_r : byte_count_r + 1'b1;
  assign sat_nxt        = sat_r | saturated;

  // Start of an occurrence ending on this byte
  assign start_w = CW'(byte_count_r) + CW'(1) - CW'(eff_len);

  // Forward keeps the first start at or above the offset; reverse the last one below it
  assign qualify = search_reverse ? (start_w < CW'(start_offset))
                                  : (!have_hit_r && (start_w >= CW'(start_offset)));
  assign record  = step.hit & ~saturated & qualify;

  assign have_hit_nxt = have_hit_r | record;
  assign hit_pos_nxt  = record ? start_w : hit_pos_r;

  // Result for a closing byte
  assign count_ext = CW'(byte_count_nxt);
  always_comb begin
    out_data_nxt.found          = have_hit_nxt;
    out_data_nxt.match_position = have_hit_nxt ? hit_pos_nxt[subloc_pkg::POS_OUT_W-1:0]
                                               : count_ext[subloc_pkg::POS_OUT_W-1:0];
    out_data_nxt.overlong       = sat_nxt;
  end

  // Stream state, cleared after each closing byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      have_hit_r   <= 1'b0;
      hit_pos_r    <= '0;
      sat_r        <= 1'b0;
    end else if (step.take) begin
      if (step.last) begin
        byte_count_r <= '0;
        have_hit_r   <= 1'b0;
        hit_pos_r    <= '0;
        sat_r        <= 1'b0;
      end else begin
        byte_count_r <= byte_count_nxt;
        have_hit_r   <= have_hit_nxt;
        hit_pos_r    <= hit_pos_nxt;
        sat_r        <= sat_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step.take && step.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.take && step.last) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SL_ASSERT_NOW(a_sat_count_full, sat_r, saturated, "overflow flag set with count not saturated")
  `SL_ASSERT_NOW(a_hit_below_count, have_hit_r, hit_pos_r < CW'(byte_count_r), "kept start not below count")
  `SL_ASSERT_NEXT(a_clear_after_last, step.take && step.last, !have_hit_r && !sat_r && (byte_count_r == '0), "stream state not cleared after last word")

endmodule

`default_nettype wire

// File: rtl/core/substring_locator_top.sv
`default_nettype none

// Latency: the result word is valid on the cycle after the word carrying the last byte.
// Throughput: one byte per cycle; the cell row and the start check are combinational.
// Only a closing byte waits, and only while an earlier result is still stalled.
// Reset (synchronous, rst_n low): registers return to pattern length 1, all else zero;
// stream state and the output valid flag clear at once, no clearing pass.
`include "substring_locator_top_macros.svh"

module substring_locator_top #(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire subloc_pkg::in_word_t               in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output subloc_pkg::out_word_t                   out_data,
  input  wire logic                               cfg_we,
  input  wire logic [subloc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [subloc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CELLS = (MAX_PATTERN < subloc_pkg::PATTERN_BYTES) ? MAX_PATTERN
                                                                   : subloc_pkg::PATTERN_BYTES;

  logic [subloc_pkg::CFG_DATA_W-1:0] pattern_low_r;
  logic [subloc_pkg::CFG_DATA_W-1:0] pattern_high_r;
  logic [subloc_pkg::LEN_W-1:0]      pattern_length_r;
  logic [subloc_pkg::OFFSET_W-1:0]   start_offset_r;
  logic                              search_reverse_r;

  logic [2*subloc_pkg::CFG_DATA_W-1:0] pattern_all;
  logic [subloc_pkg::LEN_W-1:0]        eff_len;
  logic [CELLS-1:0]                    match_bits;
  logic [CELLS-1:0]                    match_nxt;
  logic                                take;
  logic                                top_hit;
  subloc_pkg::step_t                   step;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= subloc_pkg::PATTERN_LENGTH_RESET;
      start_offset_r   <= '0;
      search_reverse_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        subloc_pkg::REG_PATTERN_LOW:    pattern_low_r    <= cfg_data;
        subloc_pkg::REG_PATTERN_HIGH:   pattern_high_r   <= cfg_data;
        subloc_pkg::REG_PATTERN_LENGTH: pattern_length_r <= cfg_data[subloc_pkg::LEN_W-1:0];
        subloc_pkg::REG_START_OFFSET:   start_offset_r   <= cfg_data[subloc_pkg::OFFSET_W-1:0];
        subloc_pkg::REG_SEARCH_REVERSE: search_reverse_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pattern length limited to the cell count
  assign eff_len = (pattern_length_r > subloc_pkg::LEN_W'(CELLS))
                   ? subloc_pkg::LEN_W'(CELLS) : pattern_length_r;
  assign pattern_all = {pattern_high_r, pattern_low_r};

  // A closing byte waits only while the previous result is held
  assign in_stall = out_valid & out_stall & in_data.last_byte;
  assign take     = in_valid & ~in_stall;

  // Row of partial-match cells
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic link;
    if (i == 0) begin : g_head
      assign link = 1'b1;
    end else begin : g_body
      assign link = match_bits[i-1];
    end

    subloc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift     (take),
      .clear     (take & in_data.last_byte),
      .active    (eff_len > subloc_pkg::LEN_W'(i)),
      .pat_byte  (pattern_all[8*i +: 8]),
      .src_byte  (in_data.source_byte),
      .match_in  (link),
      .match_r   (match_bits[i]),
      .match_nxt (match_nxt[i])
    );
  end

  // Full occurrence: the cell at the pattern's last byte lights up
  always_comb begin
    top_hit = 1'b0;
    for (int i = 0; i < CELLS; i++) begin
      if (eff_len == subloc_pkg::LEN_W'(i + 1)) begin
        top_hit = match_nxt[i];
      end
    end
  end

  always_comb begin
    step.take = take;
    step.last = in_data.last_byte;
    step.hit  = top_hit;
  end

  subloc_tracker #(
    .POSITION_BITS (POSITION_BITS)
  ) u_tracker (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .eff_len        (eff_len),
    .start_offset   (start_offset_r),
    .search_reverse (search_reverse_r),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_data       (out_data)
  );

  `SL_ASSERT_NEXT(a_cells_clear_after_last, take && in_data.last_byte, match_bits == '0, "cell row not cleared after last word")
  `SL_ASSERT_NOW(a_cells_in_length, 1'b1, (match_bits >> eff_len) == '0, "partial match beyond pattern length")
  `SL_ASSERT_NEXT(a_result_after_last, take && in_data.last_byte, out_valid, "no result after last word")

endmodule

`default_nettype wire

// File: tb/substring_locator_top_tb.sv
`default_nettype none

module substring_locator_top_tb;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_WORDS = 950;

  // One full register setting
  typedef struct packed {
    logic [63:0]                     lo;
    logic [63:0]                     hi;
    logic [subloc_pkg::LEN_W-1:0]    len;
    logic [subloc_pkg::OFFSET_W-1:0] off;
    logic                            rev;
  } search_cfg_t;

  // Directed plan: either a register setting or one input word
  typedef struct {
    bit                    is_cfg;
    search_cfg_t           cfg;
    subloc_pkg::in_word_t  w;
    bit                    typed;
    subloc_pkg::out_word_t exp;
  } plan_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  subloc_pkg::in_word_t              in_data = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  subloc_pkg::out_word_t             out_data;
  logic                              cfg_we = 1'b0;
  logic [subloc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [subloc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  substring_locator_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register mirror and stream state of the search
  search_cfg_t           active_cfg = '{64'd0, 64'd0, subloc_pkg::PATTERN_LENGTH_RESET,
                                        16'd0, 1'b0};
  logic [15:0]           run_match = '0;
  logic [15:0]           run_count = '0;
  bit                    run_hit = 1'b0;
  logic [15:0]           run_hit_pos = '0;
  bit                    run_sat = 1'b0;

  subloc_pkg::out_word_t pending_locations [$];
  plan_row_t             plan [$];
  bit                    quiet = 1'b0;
  int                    errors = 0;
  int                    words_sent = 0;
  int                    results_seen = 0;
  int                    found_seen = 0;
  int                    overlong_seen = 0;
  int                    settings_used = 0;
  int                    stall_left = 0;
  int                    cycle_count = 0;

  // Pattern length in use: anything above 16 acts as 16
  function automatic int active_len();
    return (active_cfg.len > 5'd16) ? 16 : int'(active_cfg.len);
  endfunction

  function automatic logic [7:0] pattern_byte(int i);
    return (i < 8) ? active_cfg.lo[i*8 +: 8] : active_cfg.hi[(i-8)*8 +: 8];
  endfunction

  // Advance the search by one byte; returns 1 when the byte closes the string
  function automatic bit locate_byte(input subloc_pkg::in_word_t w,
                                     output subloc_pkg::out_word_t res);
    int          len;
    int          start;
    logic [15:0] eq;
    logic [15:0] idx;
    bit          in_range;
    len = active_len();
    eq = '0;
    for (int i = 0; i < len; i++)
      if (pattern_byte(i) == w.source_byte) eq[i] = 1'b1;
    run_match = ((run_match << 1) | 16'd1) & eq;
    idx = run_count;
    in_range = 1'b1;
    // saturated count: no further positions, no further hits
    if (run_count == 16'hFFFF) begin
      run_sat = 1'b1;
      in_range = 1'b0;
    end else begin
      run_count = run_count + 16'd1;
    end
    if (in_range && len > 0 && run_match[len-1]) begin
      start = int'(idx) + 1 - len;
      if (active_cfg.rev) begin
        if (start < int'(active_cfg.off)) begin
          run_hit = 1'b1;
          run_hit_pos = start[15:0];
        end
      end else if (!run_hit && start >= int'(active_cfg.off)) begin
        run_hit = 1'b1;
        run_hit_pos = start[15:0];
      end
    end
    res = '0;
    if (!w.last_byte) return 1'b0;
    res.found = run_hit;
    res.match_position = run_hit ? run_hit_pos : run_count;
    res.overlong = run_sat;
    run_match = '0;
    run_count = '0;
    run_hit = 1'b0;
    run_hit_pos = '0;
    run_sat = 1'b0;
    return 1'b1;
  endfunction

  // Present one word, wait for it to be taken, then record what it should produce
  task automatic send_byte(input subloc_pkg::in_word_t w, input bit typed,
                           input subloc_pkg::out_word_t typed_res);
    int                    gap;
    subloc_pkg::out_word_t res;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (locate_byte(w, res)) pending_locations.push_back(typed ? typed_res : res);
    words_sent++;
  endtask

  // Rewrite all registers once the block has drained
  task automatic apply_setting(input search_cfg_t s);
    logic [subloc_pkg::CFG_IDX_W-1:0]  reg_sel [5];
    logic [subloc_pkg::CFG_DATA_W-1:0] vals [5];
    reg_sel[0] = subloc_pkg::REG_PATTERN_LOW;
    reg_sel[1] = subloc_pkg::REG_PATTERN_HIGH;
    reg_sel[2] = subloc_pkg::REG_PATTERN_LENGTH;
    reg_sel[3] = subloc_pkg::REG_START_OFFSET;
    reg_sel[4] = subloc_pkg::REG_SEARCH_REVERSE;
    vals[0] = s.lo;
    vals[1] = s.hi;
    vals[2] = subloc_pkg::CFG_DATA_W'(s.len);
    vals[3] = subloc_pkg::CFG_DATA_W'(s.off);
    vals[4] = subloc_pkg::CFG_DATA_W'(s.rev);
    in_valid <= 1'b0;
    while (pending_locations.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_sel[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    active_cfg = s;
    settings_used++;
  endtask

  function automatic search_cfg_t random_setting();
    search_cfg_t s;
    logic [7:0]  sym [2];
    logic [7:0]  b;
    bit          narrow;
    int          pick;
    s = '0;
    sym[0] = 8'($urandom);
    sym[1] = 8'($urandom);
    narrow = $urandom_range(0, 1);
    // a two-symbol pattern gives overlapping and repeated occurrences
    for (int i = 0; i < 16; i++) begin
      b = narrow ? sym[$urandom_range(0, 1)] : 8'($urandom);
      if (i < 8) s.lo[i*8 +: 8] = b;
      else s.hi[(i-8)*8 +: 8] = b;
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) s.len = 5'd0;
    else if (pick == 1) s.len = 5'($urandom_range(17, 31));
    else s.len = 5'($urandom_range(1, 16));
    pick = $urandom_range(0, 5);
    if (pick == 0) s.off = 16'd0;
    else if (pick == 1) s.off = 16'hFFFF;
    else if (pick == 2) s.off = 16'($urandom);
    else s.off = 16'($urandom_range(0, 30));
    s.rev = $urandom_range(0, 1);
    return s;
  endfunction

  // Mostly filler built from pattern bytes with whole or cut-off copies of
  // the pattern; now and then plain noise
  task automatic send_random_string();
    logic [7:0]           text [$];
    subloc_pkg::in_word_t w;
    int                   n;
    int                   eff;
    int                   cut;
    bit                   noise;
    eff = active_len();
    n = $urandom_range(1, 24);
    noise = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < n; k++) begin
      if (!noise && eff > 0 && $urandom_range(0, 4) == 0) begin
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, eff) : eff;
        for (int j = 0; j < cut; j++) text.push_back(pattern_byte(j));
      end else if (!noise && eff > 0 && $urandom_range(0, 1) == 1) begin
        text.push_back(pattern_byte($urandom_range(0, eff - 1)));
      end else begin
        text.push_back(8'($urandom));
      end
    end
    foreach (text[k]) begin
      w.source_byte = text[k];
      w.last_byte = (k == text.size() - 1);
      send_byte(w, 1'b0, '0);
    end
  endtask

  function automatic void plan_cfg(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                                   logic [15:0] off, logic rev);
    plan_row_t r;
    r = '{is_cfg: 1'b1, cfg: '{lo, hi, len, off, rev}, w: '0, typed: 1'b0, exp: '0};
    plan.push_back(r);
  endfunction

  function automatic void plan_byte(logic [7:0] b, logic last);
    plan_row_t r;
    r = '{is_cfg: 1'b0, cfg: '0, w: '{b, last}, typed: 1'b0, exp: '0};
    plan.push_back(r);
  endfunction

  // closing byte with its result written out
  function automatic void plan_end(logic [7:0] b, logic found, logic [15:0] pos);
    plan_row_t r;
    r = '{is_cfg: 1'b0, cfg: '0, w: '{b, 1'b1}, typed: 1'b1, exp: '{found, pos, 1'b0}};
    plan.push_back(r);
  endfunction

  // Result side: check each taken word, then draw the next stall
  always @(posedge clk) begin : watch_results
    subloc_pkg::out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.found === 1'b1) found_seen++;
        if (out_data.overlong === 1'b1) overlong_seen++;
        if (pending_locations.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected result found=%0b pos=%0d overlong=%0b", $time,
                     out_data.found, out_data.match_position, out_data.overlong);
        end else begin
          want = pending_locations.pop_front();
          if (out_data.found !== want.found ||
              out_data.match_position !== want.match_position ||
              out_data.overlong !== want.overlong) begin
            errors++;
            if (errors <= 40)
              $display("%0t: mismatch expected found=%0b pos=%0d overlong=%0b, got found=%0b pos=%0d overlong=%0b",
                       $time, want.found, want.match_position, want.overlong,
                       out_data.found, out_data.match_position, out_data.overlong);
          end
        end
        stall_left = quiet ? 0 : $urandom_range(0, 14);
      end else if (stall_left > 0) begin
        stall_left--;
      end
    end
    out_stall <= (stall_left > 0);
  end

  // Watchdog
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("substring_locator_top_tb: errors");
    $finish;
  end

  initial begin
    int random_goal;

    // after reset the pattern is a single zero byte
    plan_end(8'hFF, 1'b0, 16'd1);
    plan_byte(8'h00, 1'b0);
    plan_end(8'h00, 1'b1, 16'd0);
    // empty pattern never matches
    plan_cfg(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 5'd0, 16'd0, 1'b0);
    plan_byte(8'hFF, 1'b0);
    plan_end(8'hFF, 1'b0, 16'd2);
    // length field above 16 acts as 16
    plan_cfg(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, 5'd31, 16'd0, 1'b0);
    plan_end(8'h00, 1'b0, 16'd1);
    // reverse: last start below the limit
    plan_cfg(64'h6261, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 16'd2, 1'b1);
    plan_byte(8'h61, 1'b0);
    plan_byte(8'h62, 1'b0);
    plan_byte(8'h61, 1'b0);
    plan_end(8'h62, 1'b1, 16'd0);
    // forward: first start at or past the offset
    plan_cfg(64'h6261, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 16'd1, 1'b0);
    plan_byte(8'h61, 1'b0);
    plan_byte(8'h62, 1'b0);
    plan_byte(8'h61, 1'b0);
    plan_end(8'h62, 1'b1, 16'd2);
    // forward with the offset beyond the string
    plan_cfg(64'h6261, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 16'hFFFF, 1'b0);
    plan_byte(8'h61, 1'b0);
    plan_end(8'h62, 1'b0, 16'd2);
    // reverse with the limit beyond the string
    plan_cfg(64'h6261, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 16'hFFFF, 1'b1);
    plan_byte(8'h61, 1'b0);
    plan_byte(8'h61, 1'b0);
    plan_end(8'h62, 1'b1, 16'd1);
    // reverse with a zero limit finds nothing
    plan_cfg(64'h6261, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2, 16'd0, 1'b1);
    plan_byte(8'h61, 1'b0);
    plan_end(8'h62, 1'b0, 16'd2);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (plan[i]) begin
      if (plan[i].is_cfg) apply_setting(plan[i].cfg);
      else send_byte(plan[i].w, plan[i].typed, plan[i].exp);
    end

    // random settings, a handful of strings under each
    random_goal = words_sent + RANDOM_WORDS;
    while (words_sent < random_goal) begin
      apply_setting(random_setting());
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 8)) send_random_string();
    end
    quiet = 1'b0;

    // drain
    in_valid <= 1'b0;
    for (int k = 0; k < 2000 && pending_locations.size() != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_locations.size() != 0) begin
      errors += pending_locations.size();
      $display("%0t: %0d results never arrived", $time, pending_locations.size());
    end

    $display("ran %0d words under %0d register settings; %0d results checked",
             words_sent, settings_used, results_seen);
    $display("%0d results with a match, %0d with the position count saturated",
             found_seen, overlong_seen);
    if (errors == 0) begin
      $display("substring_locator_top_tb: clean");
    end else begin
      $display("substring_locator_top_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/subloc_pkg.sv
rtl/core/subloc_cell.sv
rtl/core/subloc_tracker.sv
rtl/core/substring_locator_top.sv
tb/substring_locator_top_tb.sv
